@@ hw/rtl/trbst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbst_pkg
// Shared constants and types for the text row blitter (skew and thicken).
// ----------------------------------------------------------------------------
package trbst_pkg;

    localparam int ROW_BITS   = 64;
    localparam int LANES      = 4;
    localparam int LANE_W     = ROW_BITS / LANES;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int COL_W      = $clog2(ROW_BITS);

    // skew shift state: 7 bits, saturates at 64
    localparam int SHIFT_W   = 7;
    localparam int SHIFT_MAX = 64;

    localparam int MASK_W    = 16;
    localparam int SMEAR_W   = 4;
    localparam int SMEAR_MAX = 15;
    localparam int GW_W      = 7;
    localparam int RW_W      = 7;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam int STYLE_SKEW    = 0;
    localparam int STYLE_THICKEN = 1;

    typedef enum logic [1:0] {
        WM_REPLACE     = 2'd0,
        WM_TRANSPARENT = 2'd1,
        WM_XOR         = 2'd2,
        WM_INVERSE     = 2'd3
    } wm_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_MODE    = 4'd0,
        CFG_FORE_COLOR    = 4'd1,
        CFG_AMBIENT_COLOR = 4'd2,
        CFG_STYLE_FLAGS   = 4'd3,
        CFG_SMEAR_COUNT   = 4'd4,
        CFG_GLYPH_WIDTH   = 4'd5,
        CFG_ROW_WIDTH     = 4'd6,
        CFG_SKEW_PATTERN  = 4'd7
    } cfg_idx_t;

    // settings each lane needs to write its columns
    typedef struct packed {
        wm_t             mode;
        logic            fore;
        logic            ambient;
        logic [RW_W-1:0] row_width;
    } lane_cfg_t;

endpackage

@@ hw/rtl/trbst_smear.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbst_smear
// Clips the source row to the effective glyph width and spreads each pixel
// over the smear taps.
// ----------------------------------------------------------------------------
module trbst_smear
(
    input  logic [trbst_pkg::ROW_BITS-1:0] src_row,
    input  logic                           thicken,
    input  logic [trbst_pkg::SMEAR_W-1:0]  smear_count,
    input  logic [trbst_pkg::GW_W-1:0]     glyph_width,
    output logic [trbst_pkg::ROW_BITS-1:0] smeared
);

    logic [trbst_pkg::SMEAR_W-1:0]  smear;
    logic [trbst_pkg::GW_W:0]       gw;
    logic [trbst_pkg::ROW_BITS-1:0] clipped;

    always_comb
    begin
        smear = thicken ? smear_count : trbst_pkg::SMEAR_W'(1);
        // signed effective width; top bit set means the glyph is empty
        gw = thicken ? ({1'b0, glyph_width} - (trbst_pkg::GW_W+1)'(smear_count))
                     : {1'b0, glyph_width};
        for (int j = 0; j < trbst_pkg::ROW_BITS; j++)
        begin
            clipped[j] = src_row[j] && !gw[trbst_pkg::GW_W]
                         && ((trbst_pkg::GW_W+1)'(j) < gw);
        end
        smeared = '0;
        for (int k = 0; k < trbst_pkg::SMEAR_MAX; k++)
        begin
            if (trbst_pkg::SMEAR_W'(k) < smear)
            begin
                smeared = smeared | (clipped << k);
            end
        end
    end

endmodule

@@ hw/rtl/trbst_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbst_lane
// One slice of destination columns: applies the skew offset and the write
// mode to its columns.
// ----------------------------------------------------------------------------
module trbst_lane
(
    input  logic [trbst_pkg::LANE_IDX_W-1:0] lane_idx,
    input  logic [trbst_pkg::ROW_BITS-1:0]   smeared,
    input  logic [trbst_pkg::SHIFT_W-1:0]    shift,
    input  logic [trbst_pkg::LANE_W-1:0]     dst_slice,
    input  trbst_pkg::lane_cfg_t             cfg,
    output logic [trbst_pkg::LANE_W-1:0]     out_slice
);

    logic [trbst_pkg::SHIFT_W-1:0] col;
    logic [trbst_pkg::SHIFT_W-1:0] src_idx;
    logic                          hit;
    logic                          active;

    always_comb
    begin
        col     = '0;
        src_idx = '0;
        hit     = 1'b0;
        active  = 1'b0;
        for (int i = 0; i < trbst_pkg::LANE_W; i++)
        begin
            col     = trbst_pkg::SHIFT_W'(lane_idx) * trbst_pkg::SHIFT_W'(trbst_pkg::LANE_W)
                      + trbst_pkg::SHIFT_W'(i);
            src_idx = col - shift;
            hit     = (col >= shift) && smeared[src_idx[trbst_pkg::COL_W-1:0]];
            active  = trbst_pkg::RW_W'(col) < cfg.row_width;
            out_slice[i] = dst_slice[i];
            if (active)
            begin
                unique case (cfg.mode)
                    trbst_pkg::WM_REPLACE:     out_slice[i] = hit ? cfg.fore : cfg.ambient;
                    trbst_pkg::WM_TRANSPARENT: out_slice[i] = hit ? cfg.fore : dst_slice[i];
                    trbst_pkg::WM_XOR:         out_slice[i] = dst_slice[i] ^ hit;
                    trbst_pkg::WM_INVERSE:     out_slice[i] = hit ? dst_slice[i] : cfg.fore;
                    default:                   out_slice[i] = dst_slice[i];
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/text_row_blit_skew_thicken_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_row_blit_skew_thicken_top
// Single-plane glyph row blitter with skew and thicken (bold) styling.
// ----------------------------------------------------------------------------
// Takes one glyph row per cycle while the output side is not stalled (or
// while stage one is empty) and returns the updated destination row from
// the output register. The first stage updates the skew state and clips and
// smears the source row; the second stage splits the row across four column
// lanes that apply the skew offset and write mode, and their slices are
// merged into the output register. Configuration writes are accepted in any
// cycle and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module text_row_blit_skew_thicken_top
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [trbst_pkg::ROW_BITS-1:0]   src_row,
    input  logic [trbst_pkg::ROW_BITS-1:0]   dst_row,
    input  logic                             first_row,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [trbst_pkg::ROW_BITS-1:0]   dst_row_out,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trbst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trbst_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    trbst_pkg::wm_t                write_mode_reg;
    logic                          fore_color_reg;
    logic                          ambient_color_reg;
    logic [1:0]                    style_flags_reg;
    logic [trbst_pkg::SMEAR_W-1:0] smear_count_reg;
    logic [trbst_pkg::GW_W-1:0]    glyph_width_reg;
    logic [trbst_pkg::RW_W-1:0]    row_width_reg;
    logic [trbst_pkg::MASK_W-1:0]  skew_pattern_reg;

    // skew state
    logic [trbst_pkg::SHIFT_W-1:0] skew_shift_reg;
    logic [trbst_pkg::SHIFT_W-1:0] skew_shift_next;
    logic [trbst_pkg::MASK_W-1:0]  skew_mask_reg;
    logic [trbst_pkg::MASK_W-1:0]  skew_mask_next;

    // pipeline
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    logic [trbst_pkg::ROW_BITS-1:0] s1_smeared_reg;
    logic [trbst_pkg::ROW_BITS-1:0] s1_dst_reg;
    logic [trbst_pkg::SHIFT_W-1:0]  s1_shift_reg;
    logic [trbst_pkg::ROW_BITS-1:0] s2_out_reg;
    logic [trbst_pkg::ROW_BITS-1:0] s2_out_next;

    logic                           in_acc;
    logic                           s2_adv;
    logic [trbst_pkg::ROW_BITS-1:0] smeared;
    trbst_pkg::lane_cfg_t           lane_cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_mode_reg    <= trbst_pkg::WM_REPLACE;
            fore_color_reg    <= 1'b1;
            ambient_color_reg <= 1'b0;
            style_flags_reg   <= '0;
            smear_count_reg   <= trbst_pkg::SMEAR_W'(1);
            glyph_width_reg   <= trbst_pkg::GW_W'(8);
            row_width_reg     <= trbst_pkg::RW_W'(8);
            skew_pattern_reg  <= trbst_pkg::MASK_W'(16'h5555);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (trbst_pkg::cfg_idx_t'(cfg_index))
                trbst_pkg::CFG_WRITE_MODE:    write_mode_reg    <= trbst_pkg::wm_t'(cfg_data[1:0]);
                trbst_pkg::CFG_FORE_COLOR:    fore_color_reg    <= cfg_data[0];
                trbst_pkg::CFG_AMBIENT_COLOR: ambient_color_reg <= cfg_data[0];
                trbst_pkg::CFG_STYLE_FLAGS:   style_flags_reg   <= cfg_data[1:0];
                trbst_pkg::CFG_SMEAR_COUNT:   smear_count_reg   <= cfg_data[trbst_pkg::SMEAR_W-1:0];
                trbst_pkg::CFG_GLYPH_WIDTH:   glyph_width_reg   <= cfg_data[trbst_pkg::GW_W-1:0];
                trbst_pkg::CFG_ROW_WIDTH:     row_width_reg     <= cfg_data[trbst_pkg::RW_W-1:0];
                trbst_pkg::CFG_SKEW_PATTERN:  skew_pattern_reg  <= cfg_data[trbst_pkg::MASK_W-1:0];
                default:                      ;
            endcase
        end
    end

    // handshake: the output register frees up when taken, stage one follows
    assign s2_adv   = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_adv;
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = in_acc || (s1_valid_reg && !s2_adv);
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
    end

    // new glyph resets the state, then the skew step for this row
    always_comb
    begin
        skew_shift_next = skew_shift_reg;
        skew_mask_next  = skew_mask_reg;
        if (first_row)
        begin
            skew_shift_next = '0;
            skew_mask_next  = skew_pattern_reg;
        end
        if (style_flags_reg[trbst_pkg::STYLE_SKEW])
        begin
            if (skew_mask_next[trbst_pkg::MASK_W-1]
                && (skew_shift_next < trbst_pkg::SHIFT_W'(trbst_pkg::SHIFT_MAX)))
            begin
                skew_shift_next = skew_shift_next + trbst_pkg::SHIFT_W'(1);
            end
            skew_mask_next = {skew_mask_next[trbst_pkg::MASK_W-2:0],
                              skew_mask_next[trbst_pkg::MASK_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            skew_shift_reg <= '0;
            skew_mask_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (in_acc)
            begin
                skew_shift_reg <= skew_shift_next;
                skew_mask_reg  <= skew_mask_next;
            end
        end
    end

    trbst_smear u_smear
    (
        .src_row     (src_row),
        .thicken     (style_flags_reg[trbst_pkg::STYLE_THICKEN]),
        .smear_count (smear_count_reg),
        .glyph_width (glyph_width_reg),
        .smeared     (smeared)
    );

    assign lane_cfg = '{mode:      write_mode_reg,
                        fore:      fore_color_reg,
                        ambient:   ambient_color_reg,
                        row_width: row_width_reg};

    for (genvar l = 0; l < trbst_pkg::LANES; l++)
    begin : g_lane
        trbst_lane u_lane
        (
            .lane_idx  (trbst_pkg::LANE_IDX_W'(l)),
            .smeared   (s1_smeared_reg),
            .shift     (s1_shift_reg),
            .dst_slice (s1_dst_reg[l*trbst_pkg::LANE_W +: trbst_pkg::LANE_W]),
            .cfg       (lane_cfg),
            .out_slice (s2_out_next[l*trbst_pkg::LANE_W +: trbst_pkg::LANE_W])
        );
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_smeared_reg <= smeared;
            s1_dst_reg     <= dst_row;
            s1_shift_reg   <= skew_shift_next;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_out_reg <= s2_out_next;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign dst_row_out = s2_out_reg;

    // shift saturates and never passes its ceiling
    a_shift_sat: assert property (@(posedge clk) disable iff (!rst_n)
        skew_shift_reg <= trbst_pkg::SHIFT_W'(trbst_pkg::SHIFT_MAX))
        else $error("skew shift beyond saturation");

    // a first row with skew off leaves the freshly loaded state
    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && first_row && !style_flags_reg[trbst_pkg::STYLE_SKEW])
        |=> (skew_shift_reg == '0 && skew_mask_reg == $past(skew_pattern_reg)))
        else $error("first row did not reload skew state");

    // an item held in stage one while the output stalls is not dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_adv) |=> s1_valid_reg && s2_valid_reg)
        else $error("stage one item lost during output stall");

    // an empty stage one always leaves room for a new item
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input blocked with stage one empty");

endmodule
